// File: rtl/scfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sync checksum frame parser package
// Shared constants, result codes and the configuration bundle.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam int unsigned FRAME_LEN = 7;
    localparam int unsigned HEAD_LEN  = FRAME_LEN - 2;
    localparam int unsigned COUNT_W   = $clog2(FRAME_LEN);
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hCB;
    localparam logic [BYTE_W-1:0] ERROR_LIMIT_RESET = 8'd50;
    localparam logic [BYTE_W-1:0] COUNT_MAX         = 8'hFF;

    typedef enum logic [1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_ERROR_LIMIT = 2'd2
    } reg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GOOD   = 2'd0,
        STATUS_BAD    = 2'd1,
        STATUS_HALTED = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] error_limit;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        status_t             status;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/scfp_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the sync pair and the error limit.
// ----------------------------------------------------------------------------
module scfp_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [scfp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [scfp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [scfp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output scfp_pkg::cfg_t                        cfg
);

    scfp_pkg::cfg_t         cfg_reg;
    scfp_pkg::reg_index_t   index;
    logic                   wr_en;

    assign index  = scfp_pkg::reg_index_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= scfp_pkg::SYNC_FIRST_RESET;
            cfg_reg.sync_second <= scfp_pkg::SYNC_SECOND_RESET;
            cfg_reg.error_limit <= scfp_pkg::ERROR_LIMIT_RESET;
        end else if (wr_en) begin
            case (index)
                scfp_pkg::REG_SYNC_FIRST: begin
                    cfg_reg.sync_first <= pwdata[scfp_pkg::BYTE_W-1:0];
                end
                scfp_pkg::REG_SYNC_SECOND: begin
                    cfg_reg.sync_second <= pwdata[scfp_pkg::BYTE_W-1:0];
                end
                scfp_pkg::REG_ERROR_LIMIT: begin
                    cfg_reg.error_limit <= pwdata[scfp_pkg::BYTE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (index)
            scfp_pkg::REG_SYNC_FIRST: begin
                prdata = {{(scfp_pkg::CFG_DATA_W-scfp_pkg::BYTE_W){1'b0}}, cfg_reg.sync_first};
            end
            scfp_pkg::REG_SYNC_SECOND: begin
                prdata = {{(scfp_pkg::CFG_DATA_W-scfp_pkg::BYTE_W){1'b0}}, cfg_reg.sync_second};
            end
            scfp_pkg::REG_ERROR_LIMIT: begin
                prdata = {{(scfp_pkg::CFG_DATA_W-scfp_pkg::BYTE_W){1'b0}}, cfg_reg.error_limit};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/scfp_frame_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame core
// Holds the open frame and the error state, and decides each byte's result.
// ----------------------------------------------------------------------------
module scfp_frame_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          byte_en,
    input  wire logic [scfp_pkg::BYTE_W-1:0]   rx_byte,
    input  wire scfp_pkg::cfg_t                cfg,
    output logic                               res_valid,
    output scfp_pkg::result_t                  res
);

    logic [scfp_pkg::BYTE_W-1:0]   head_reg [scfp_pkg::HEAD_LEN];
    logic [scfp_pkg::BYTE_W-1:0]   prev_reg;
    logic [scfp_pkg::COUNT_W-1:0]  byte_count_reg;
    logic [scfp_pkg::COUNT_W-1:0]  byte_count_next;
    logic [scfp_pkg::BYTE_W-1:0]   bad_count_reg;
    logic [scfp_pkg::BYTE_W-1:0]   bad_count_next;
    logic                          halted_reg;
    logic                          halted_next;

    logic                          active;
    logic                          full;
    logic                          pair_hit;
    logic                          closes;
    logic                          sum_ok;
    logic                          good;
    logic [scfp_pkg::BYTE_W-1:0]   sum;
    logic [scfp_pkg::BYTE_W-1:0]   bad_count_inc;
    logic                          limit_hit;

    assign active   = byte_en && !halted_reg;
    assign full     = byte_count_reg == scfp_pkg::COUNT_W'(scfp_pkg::FRAME_LEN - 1);
    assign pair_hit = (prev_reg == cfg.sync_first) && (rx_byte == cfg.sync_second);
    assign closes   = full || ((byte_count_reg != '0) && pair_hit);
    assign sum      = head_reg[0] + head_reg[2] + head_reg[3] + head_reg[4];
    assign sum_ok   = sum == head_reg[1];
    assign good     = full && pair_hit && sum_ok;

    assign bad_count_inc = (bad_count_reg == scfp_pkg::COUNT_MAX) ? bad_count_reg
                                                                  : bad_count_reg + 1'b1;
    assign limit_hit     = bad_count_inc >= cfg.error_limit;

    always_comb begin
        byte_count_next = byte_count_reg;
        bad_count_next  = bad_count_reg;
        halted_next     = halted_reg;
        res_valid       = 1'b0;
        res.sample      = '0;
        res.status      = scfp_pkg::STATUS_GOOD;
        if (active) begin
            if (closes) begin
                res_valid       = 1'b1;
                byte_count_next = '0;
                if (good) begin
                    res.sample     = {head_reg[3], head_reg[4]};
                    bad_count_next = '0;
                end else begin
                    bad_count_next = bad_count_inc;
                    if (limit_hit) begin
                        halted_next = 1'b1;
                        res.status  = scfp_pkg::STATUS_HALTED;
                    end else begin
                        res.status  = scfp_pkg::STATUS_BAD;
                    end
                end
            end else begin
                byte_count_next = byte_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            bad_count_reg  <= '0;
            halted_reg     <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            bad_count_reg  <= bad_count_next;
            halted_reg     <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (active) begin
            prev_reg <= rx_byte;
            for (int i = 0; i < scfp_pkg::HEAD_LEN; i++) begin
                if (byte_count_reg == scfp_pkg::COUNT_W'(i)) begin
                    head_reg[i] <= rx_byte;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/sync_checksum_frame_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sync checksum frame parser
// Collects received bytes into frames, checks sync pair and checksum, and
// reports one sample or status transaction for each closed frame.
// ----------------------------------------------------------------------------
// Each accepted byte is held in the input register, and the result it closes is then registered in the result register.
// Throughput: one byte per cycle while the result output is not stalled, set by the input and result registers.
// The input register lets one new byte enter while a result waits in the result register.
// Reset is synchronous and active low; it clears frame, error and halt state
// and restores the configuration registers to their defaults.
module sync_checksum_frame_parser_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [15:0]                       m_axis_tdata,  // [15:0] sample
    output logic      [1:0]                        m_axis_tuser,  // [1:0] status
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [scfp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [scfp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [scfp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    scfp_pkg::cfg_t                 cfg;
    logic                           in_valid_reg;
    logic [scfp_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                           out_valid_reg;
    scfp_pkg::result_t              out_reg;
    logic                           out_free;
    logic                           byte_en;
    logic                           res_valid;
    scfp_pkg::result_t              res;

    scfp_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scfp_frame_core u_frame_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (byte_en),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign byte_en       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.sample;
    assign m_axis_tuser  = out_reg.status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (byte_en && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_en && res_valid) begin
            out_reg <= res;
        end
    end

endmodule
`default_nettype wire
